FILE: rtl/dnsc_pkg.sv
// ----------------------------------------------------------------------------
// dnsc_pkg: shared types and constants of the dns name syntax checker
// widths, character codes, check kinds and the per-name state record
// ----------------------------------------------------------------------------
package dnsc_pkg;

  localparam int CHAR_W      = 8;
  localparam int NAME_LEN_W  = 9;
  localparam int LABEL_LEN_W = 7;

  localparam int DEF_MAX_NAME_LENGTH  = 253;
  localparam int DEF_MAX_LABEL_LENGTH = 63;

  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;

  localparam logic [NAME_LEN_W-1:0] NAME_LEN_CAP = '1;

  typedef enum logic {
    KIND_DOMAIN = 1'b0,
    KIND_LABEL  = 1'b1
  } check_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_byte;
    logic              empty_string;
  } char_item_t;

  typedef struct packed {
    logic [NAME_LEN_W-1:0]  name_length;
    logic [LABEL_LEN_W-1:0] label_length;
    logic                   previous_was_hyphen;
    logic                   failed;
  } name_state_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage

FILE: rtl/dnsc_in_if.sv
// ----------------------------------------------------------------------------
// dnsc_in_if: byte channel of the name checker
// valid/ready handshake carrying one byte of a name per item
// ----------------------------------------------------------------------------
interface dnsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [dnsc_pkg::CHAR_W-1:0] char_code;
  logic                      last_byte;
  logic                      empty_string;

  modport source (output valid, output char_code, output last_byte,
                  output empty_string, input ready);
  modport sink   (input valid, input char_code, input last_byte,
                  input empty_string, output ready);
endinterface

FILE: rtl/dnsc_out_if.sv
// ----------------------------------------------------------------------------
// dnsc_out_if: verdict channel of the name checker
// valid/ready handshake carrying one verdict per item
// ----------------------------------------------------------------------------
interface dnsc_out_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

FILE: rtl/dnsc_state.sv
// ----------------------------------------------------------------------------
// dnsc_state: per-name rule tracking
// holds the name state, folds in one byte per step and judges the name end
// ----------------------------------------------------------------------------
module dnsc_state #(
  parameter int MAX_NAME_LENGTH  = dnsc_pkg::DEF_MAX_NAME_LENGTH,
  parameter int MAX_LABEL_LENGTH = dnsc_pkg::DEF_MAX_LABEL_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  dnsc_pkg::char_item_t  item,
  input  dnsc_pkg::check_kind_t kind,
  output logic                  verdict
);

  localparam logic [dnsc_pkg::NAME_LEN_W-1:0] NAME_MAX =
    dnsc_pkg::NAME_LEN_W'(MAX_NAME_LENGTH);
  localparam logic [dnsc_pkg::NAME_LEN_W-1:0] LABEL_MAX_N =
    dnsc_pkg::NAME_LEN_W'(MAX_LABEL_LENGTH);
  localparam logic [dnsc_pkg::LABEL_LEN_W-1:0] LABEL_MAX =
    dnsc_pkg::LABEL_LEN_W'(MAX_LABEL_LENGTH);

  dnsc_pkg::name_state_t st;
  dnsc_pkg::name_state_t st_upd;
  dnsc_pkg::name_state_t st_next;

  logic alnum;
  logic hyphen;
  logic dot;

  assign alnum  = dnsc_pkg::is_alnum(item.char_code);
  assign hyphen = (item.char_code == dnsc_pkg::CH_HYPHEN);
  assign dot    = (item.char_code == dnsc_pkg::CH_DOT);

  // fold the byte into the state
  always_comb begin
    st_upd = st;
    if (!item.empty_string) begin
      unique case (kind)
        dnsc_pkg::KIND_LABEL: begin
          if (!alnum && !hyphen) st_upd.failed = 1'b1;
          if (st.name_length == '0 && !alnum) st_upd.failed = 1'b1;
          st_upd.previous_was_hyphen = !alnum;
          if (st.name_length != dnsc_pkg::NAME_LEN_CAP)
            st_upd.name_length = st.name_length + 1'b1;
        end
        dnsc_pkg::KIND_DOMAIN: begin
          // a dot in the final byte is the stripped trailing dot
          if (!(item.last_byte && dot)) begin
            if (dot) begin
              if (st.label_length == '0 || st.previous_was_hyphen) st_upd.failed = 1'b1;
              st_upd.label_length        = '0;
              st_upd.previous_was_hyphen = 1'b0;
            end else if (alnum || hyphen) begin
              if (hyphen && st.label_length == '0) st_upd.failed = 1'b1;
              if (st.label_length >= LABEL_MAX) st_upd.failed = 1'b1;
              else st_upd.label_length = st.label_length + 1'b1;
              st_upd.previous_was_hyphen = hyphen;
            end else begin
              st_upd.failed              = 1'b1;
              st_upd.previous_was_hyphen = 1'b0;
            end
            if (st.name_length != dnsc_pkg::NAME_LEN_CAP)
              st_upd.name_length = st.name_length + 1'b1;
          end
        end
        default: st_upd = st;
      endcase
    end
  end

  // judge the name as it stands after this byte
  always_comb begin
    unique case (kind)
      dnsc_pkg::KIND_LABEL:
        verdict = (st_upd.name_length == '0) ? st_upd.failed :
                  (st_upd.failed || st_upd.previous_was_hyphen ||
                   st_upd.name_length > LABEL_MAX_N);
      dnsc_pkg::KIND_DOMAIN:
        verdict = st_upd.failed || st_upd.label_length == '0 ||
                  st_upd.previous_was_hyphen || st_upd.name_length == '0 ||
                  st_upd.name_length > NAME_MAX;
      default: verdict = 1'b1;
    endcase
  end

  always_comb begin
    st_next = st;
    if (step) begin
      if (item.last_byte) st_next = '0;
      else st_next = st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

FILE: rtl/dns_name_syntax_checker_top.sv
// ----------------------------------------------------------------------------
// dns_name_syntax_checker_top: hostname / label syntax checker
// streams a name in byte by byte and returns one valid/invalid verdict
// ----------------------------------------------------------------------------
// Bytes of a name arrive on chars, one per item, and the item that carries
// last_byte produces one verdict on verdicts (0 valid, 1 invalid); other
// items produce nothing. The block takes one byte every clock: a byte is
// registered, folded into the name state and, on the last byte, judged, and
// the verdict is held in the output register and offered there until it is
// taken. The output register lets the next name stream in while a verdict
// waits to be taken; only a last byte waits in the input register while an
// earlier verdict is still untaken, and that holds off the byte behind it.
// check_kind selects dotted domain checking (0) or single-label checking
// (1); write it only while no name is in flight.
module dns_name_syntax_checker_top #(
  parameter int MAX_NAME_LENGTH  = dnsc_pkg::DEF_MAX_NAME_LENGTH,
  parameter int MAX_LABEL_LENGTH = dnsc_pkg::DEF_MAX_LABEL_LENGTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  dnsc_in_if.sink      chars,
  dnsc_out_if.source   verdicts
);

  // mode register
  dnsc_pkg::check_kind_t kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= dnsc_pkg::KIND_DOMAIN;
    end else if (cfg_we) begin
      kind <= dnsc_pkg::check_kind_t'(cfg_wdata);
    end
  end

  // input register
  logic                 s1_valid;
  dnsc_pkg::char_item_t s1_item;
  logic                 advance;
  logic                 step_verdict;

  // result register
  logic out_valid;
  logic out_verdict;

  // a byte without a verdict always moves on; a last byte needs a free slot
  assign advance     = s1_valid &&
                       (!s1_item.last_byte || !out_valid || verdicts.ready);
  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_item.char_code    <= chars.char_code;
      s1_item.last_byte    <= chars.last_byte;
      s1_item.empty_string <= chars.empty_string;
    end
  end

  // rule tracking for the byte in the input register
  dnsc_state #(
    .MAX_NAME_LENGTH  (MAX_NAME_LENGTH),
    .MAX_LABEL_LENGTH (MAX_LABEL_LENGTH)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (s1_item),
    .kind    (kind),
    .verdict (step_verdict)
  );

  // verdict holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.last_byte) begin
      out_verdict <= step_verdict;
    end
  end

  assign verdicts.valid   = out_valid;
  assign verdicts.verdict = out_verdict;

endmodule
